// ===== rtl/core/dhis_pkg.sv =====
`timescale 1ns / 1ps
package dhis_pkg;

  // Default sizing: the slot table is a power of two, at least twice the capacity
  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned SLOTS_DEF    = 512;

  // Fixed field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 9;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  // Result codes
  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ERASED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

endpackage

// ===== rtl/core/double_hash_int_set.sv =====
`timescale 1ns / 1ps
// Sequence: an operation is accepted in S_IDLE, each probed slot is read (S_P_RD) and checked
// (S_P_EVAL, plus S_P_CMP to compare the stored key), then S_ACT updates and S_DONE loads the
// output register; the slot and key memory read ports (one read each a cycle) set the pace.
// One item at a time: in_stall stays high until the result is loaded; erase also clears the
// slot table in S_CLR and reinserts every remaining key. Reset: synchronous; the slot table
// is cleared by a pass over every slot during which in_stall is high. The key memory is not cleared.
module double_hash_int_set #(
  parameter int unsigned CAPACITY = dhis_pkg::CAPACITY_DEF,
  parameter int unsigned SLOTS    = dhis_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dhis_pkg::MODE_W-1:0]     mode,
  input  logic signed [dhis_pkg::KEY_W-1:0] key,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dhis_pkg::INDEX_W-1:0]    index,
  output logic [dhis_pkg::STATUS_W-1:0]   status,
  output logic [dhis_pkg::COUNT_W-1:0]    count
);

  localparam int unsigned IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned SW   = $clog2(SLOTS);
  localparam int unsigned KW   = dhis_pkg::KEY_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_P_RD, S_P_EVAL, S_P_CMP, S_ACT, S_E_MV,
    S_RB_RD, S_RB_K, S_RB_S, S_RB_CHK, S_DONE
  } state_t;

  state_t state;

  // Memories
  logic [KW-1:0]   key_mem  [CAPACITY];
  logic [IDXW:0]   slot_mem [SLOTS];
  logic [KW-1:0]   key_q;
  logic [IDXW:0]   slot_q;

  logic [IDXW-1:0] key_ra, key_wa;
  logic [KW-1:0]   key_wd;
  logic            key_we;
  logic [SW-1:0]   slot_ra, slot_wa;
  logic [IDXW:0]   slot_wd;
  logic            slot_we;

  // Working registers
  localparam int unsigned MODE_W_L = dhis_pkg::MODE_W;
  logic [MODE_W_L-1:0] op;
  logic [KW-1:0]   k;
  logic [SW-1:0]   s;
  logic [SW-1:0]   stp;
  logic [SW:0]     n;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   ri;
  logic [SW-1:0]   clr;
  logic            rb;
  logic            found;
  logic            ok;
  logic [IDXW-1:0] fidx;
  logic [IDXW-1:0] ridx;
  logic [dhis_pkg::STATUS_W-1:0] rst_code;

  logic [KW-1:0]   sh_k;
  logic [SW-1:0]   stp_k;
  logic [KW-1:0]   sh_q;
  logic [SW-1:0]   stp_q;
  logic [IDXW-1:0] slot_idx;
  logic [IDXW-1:0] cnt_lo;
  logic [IDXW-1:0] cnt_m1;
  logic [IDXW-1:0] ri_m1;
  logic [IDXW+dhis_pkg::INDEX_W-1:0] idx_ext;
  logic [CW+dhis_pkg::COUNT_W-1:0]   cnt_ext;

  // Odd probe step for the input key and for a key read back from memory
  assign sh_k  = KW'($signed(key) >>> 8);
  assign stp_k = (key[SW-1:0] ^ sh_k[SW-1:0]) | SW'(1);
  assign sh_q  = KW'($signed(key_q) >>> 8);
  assign stp_q = (key_q[SW-1:0] ^ sh_q[SW-1:0]) | SW'(1);

  assign slot_idx = slot_q[IDXW-1:0];
  assign cnt_lo   = cnt[IDXW-1:0];
  assign cnt_m1   = IDXW'(cnt - CW'(1));
  assign ri_m1    = IDXW'(ri - CW'(1));
  assign idx_ext  = {{dhis_pkg::INDEX_W{1'b0}}, ridx};
  assign cnt_ext  = {{dhis_pkg::COUNT_W{1'b0}}, cnt};

  assign in_stall = (state != S_IDLE);

  // Drive memory ports from the current step
  always_comb begin
    key_ra  = fidx;
    slot_ra = s;
    key_we  = 1'b0;
    key_wa  = cnt_lo;
    key_wd  = k;
    slot_we = 1'b0;
    slot_wa = s;
    slot_wd = {1'b1, cnt_lo};
    case (state)
      S_CLR: begin
        slot_we = 1'b1;
        slot_wa = clr;
        slot_wd = '0;
      end
      S_P_EVAL: key_ra = slot_idx;
      S_ACT: begin
        key_ra = cnt_m1;
        if (op == dhis_pkg::MODE_INSERT && !found && ok && cnt < CW'(CAPACITY)) begin
          key_we  = 1'b1;
          slot_we = 1'b1;
        end
      end
      S_E_MV: begin
        key_we = 1'b1;
        key_wa = fidx;
        key_wd = key_q;
      end
      S_RB_RD: key_ra = ri_m1;
      S_RB_CHK: begin
        if (!slot_q[IDXW]) begin
          slot_we = 1'b1;
          slot_wd = {1'b1, ri_m1};
        end
      end
      default: ;
    endcase
  end

  // Key memory
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    key_q <= key_mem[key_ra];
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_q <= slot_mem[slot_ra];
  end

  // Sequencer: probe, update, rebuild, deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      rb        <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop a delivered beat unless a new one loads this cycle
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr <= clr + SW'(1);
          if (clr == SW'(SLOTS - 1)) begin
            state <= rb ? S_RB_RD : S_IDLE;
            ri    <= cnt;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op    <= mode;
            k     <= key;
            s     <= key[SW-1:0];
            stp   <= stp_k;
            n     <= '0;
            state <= S_P_RD;
          end
        end
        S_P_RD: state <= S_P_EVAL;
        S_P_EVAL: begin
          if (!slot_q[IDXW]) begin
            found <= 1'b0;
            ok    <= 1'b1;
            state <= S_ACT;
          end else if ({{(CW > IDXW ? CW - IDXW : 1){1'b0}}, slot_idx} < (CW + 1)'(cnt)) begin
            fidx  <= slot_idx;
            state <= S_P_CMP;
          end else begin
            s <= s + stp;
            n <= n + (SW + 1)'(1);
            if (n == (SW + 1)'(SLOTS - 1)) begin
              found <= 1'b0;
              ok    <= 1'b0;
              state <= S_ACT;
            end else begin
              state <= S_P_RD;
            end
          end
        end
        S_P_CMP: begin
          if (key_q == k) begin
            found <= 1'b1;
            ok    <= 1'b1;
            state <= S_ACT;
          end else begin
            s <= s + stp;
            n <= n + (SW + 1)'(1);
            if (n == (SW + 1)'(SLOTS - 1)) begin
              found <= 1'b0;
              ok    <= 1'b0;
              state <= S_ACT;
            end else begin
              state <= S_P_RD;
            end
          end
        end
        S_ACT: begin
          state <= S_DONE;
          ridx  <= '0;
          rst_code <= dhis_pkg::ST_ABSENT;
          case (op)
            dhis_pkg::MODE_INSERT: begin
              if (found) begin
                ridx     <= fidx;
                rst_code <= dhis_pkg::ST_PRESENT;
              end else if (!ok || cnt >= CW'(CAPACITY)) begin
                rst_code <= dhis_pkg::ST_FULL;
              end else begin
                ridx     <= cnt_lo;
                rst_code <= dhis_pkg::ST_NEW;
                cnt      <= cnt + CW'(1);
              end
            end
            dhis_pkg::MODE_ERASE: begin
              if (found && cnt != '0) begin
                ridx     <= fidx;
                rst_code <= dhis_pkg::ST_ERASED;
                cnt      <= cnt - CW'(1);
                state    <= S_E_MV;
              end
            end
            default: begin
              if (found) begin
                ridx     <= fidx;
                rst_code <= dhis_pkg::ST_PRESENT;
              end
            end
          endcase
        end
        S_E_MV: begin
          // last key moved; clear the table and reinsert
          rb    <= 1'b1;
          clr   <= '0;
          state <= S_CLR;
        end
        S_RB_RD: begin
          if (ri == '0) begin
            rb    <= 1'b0;
            state <= S_DONE;
          end else begin
            state <= S_RB_K;
          end
        end
        S_RB_K: begin
          s     <= key_q[SW-1:0];
          stp   <= stp_q;
          state <= S_RB_S;
        end
        S_RB_S: state <= S_RB_CHK;
        S_RB_CHK: begin
          if (slot_q[IDXW]) begin
            s     <= s + stp;
            state <= S_RB_S;
          end else begin
            ri    <= ri - CW'(1);
            state <= S_RB_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            index     <= idx_ext[dhis_pkg::INDEX_W-1:0];
            status    <= rst_code;
            count     <= cnt_ext[dhis_pkg::COUNT_W-1:0];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("key count above capacity");

  a_full_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == dhis_pkg::ST_FULL |-> index == '0)
    else $error("full result with nonzero index");

  a_new_cnt: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && status == dhis_pkg::ST_NEW |-> count != '0)
    else $error("insert reported with empty set");

endmodule

// ===== tb/double_hash_int_set_tb.sv =====
`timescale 1ns / 1ps
module double_hash_int_set_tb;

  localparam int unsigned CAP   = dhis_pkg::CAPACITY_DEF;
  localparam int unsigned NSLOT = dhis_pkg::SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [dhis_pkg::INDEX_W-1:0]  index;
    logic [dhis_pkg::STATUS_W-1:0] status;
    logic [dhis_pkg::COUNT_W-1:0]  count;
  } set_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [dhis_pkg::MODE_W-1:0] mode;
  logic signed [dhis_pkg::KEY_W-1:0] key;
  logic out_valid;
  logic out_stall;
  logic [dhis_pkg::INDEX_W-1:0] index;
  logic [dhis_pkg::STATUS_W-1:0] status;
  logic [dhis_pkg::COUNT_W-1:0] count;

  // Shadow of the set contents
  logic [dhis_pkg::KEY_W-1:0] shadow_keys [CAP];
  logic [8:0]       shadow_slot [NSLOT];
  bit               shadow_used [NSLOT];
  int unsigned      shadow_count;

  set_result_t expected_results [$];
  int unsigned errors;
  int unsigned beats_out;
  int unsigned cycles;
  bit          stall_enable;
  int unsigned n_erased, n_full;

  double_hash_int_set i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .key(key),
    .out_valid(out_valid), .out_stall(out_stall),
    .index(index), .status(status), .count(count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t, %0d results outstanding", $time, expected_results.size());
      $display("double_hash_int_set: mismatch");
      $finish;
    end
  end

  function automatic logic [dhis_pkg::KEY_W-1:0] probe_step(logic [dhis_pkg::KEY_W-1:0] k);
    logic [dhis_pkg::KEY_W-1:0] sh;
    sh = $signed(k) >>> 8;
    return (k ^ sh) | 32'd1;
  endfunction

  // Find the slot holding k or the first free slot on its path
  task automatic find_slot(input logic [dhis_pkg::KEY_W-1:0] k, output int unsigned slot,
                           output bit found, output bit ok);
    int unsigned s;
    int unsigned stp;
    s = k & (NSLOT - 1);
    stp = probe_step(k);
    found = 0;
    ok = 0;
    slot = 0;
    for (int n = 0; n < NSLOT; n++) begin
      if (!shadow_used[s]) begin
        slot = s;
        ok = 1;
        return;
      end
      if (shadow_slot[s] < shadow_count && shadow_keys[shadow_slot[s]] == k) begin
        slot = s;
        found = 1;
        ok = 1;
        return;
      end
      s = (s + stp) & (NSLOT - 1);
    end
  endtask

  task automatic rebuild_slots();
    int unsigned s;
    int unsigned stp;
    int unsigned n;
    foreach (shadow_used[i]) shadow_used[i] = 0;
    for (int i = shadow_count; i > 0; i--) begin
      s = shadow_keys[i-1] & (NSLOT - 1);
      stp = probe_step(shadow_keys[i-1]);
      n = 0;
      while (shadow_used[s] && n < NSLOT) begin
        s = (s + stp) & (NSLOT - 1);
        n++;
      end
      if (!shadow_used[s]) begin
        shadow_used[s] = 1;
        shadow_slot[s] = 9'(i - 1);
      end
    end
  endtask

  // Apply one operation to the shadow and return its result
  task automatic apply_set_op(input logic [dhis_pkg::MODE_W-1:0] m,
                              input logic [dhis_pkg::KEY_W-1:0] k,
                              output set_result_t r);
    int unsigned slot;
    int unsigned d;
    bit found, ok;
    find_slot(k, slot, found, ok);
    r.index = '0;
    r.status = dhis_pkg::ST_ABSENT;
    if (m == dhis_pkg::MODE_INSERT) begin
      if (found) begin
        r.index = shadow_slot[slot][dhis_pkg::INDEX_W-1:0];
        r.status = dhis_pkg::ST_PRESENT;
      end else if (!ok || shadow_count >= CAP) begin
        r.status = dhis_pkg::ST_FULL;
        n_full++;
      end else begin
        r.index = (dhis_pkg::INDEX_W)'(shadow_count);
        shadow_keys[shadow_count] = k;
        shadow_slot[slot] = 9'(shadow_count);
        shadow_used[slot] = 1;
        shadow_count++;
        r.status = dhis_pkg::ST_NEW;
      end
    end else if (m == dhis_pkg::MODE_ERASE) begin
      if (found && shadow_count > 0) begin
        d = shadow_slot[slot];
        shadow_count--;
        shadow_keys[d] = shadow_keys[shadow_count];
        rebuild_slots();
        r.index = (dhis_pkg::INDEX_W)'(d);
        r.status = dhis_pkg::ST_ERASED;
        n_erased++;
      end
    end else if (found) begin
      r.index = shadow_slot[slot][dhis_pkg::INDEX_W-1:0];
      r.status = dhis_pkg::ST_PRESENT;
    end
    r.count = (dhis_pkg::COUNT_W)'(shadow_count);
  endtask

  // Send one beat, with an optional random gap before it; valid stays up
  // after the accepting edge until the next beat or an idle period
  task automatic send_op(input logic [dhis_pkg::MODE_W-1:0] m,
                         input logic [dhis_pkg::KEY_W-1:0] k);
    set_result_t r;
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    key <= k;
    do @(posedge clk); while (in_stall);
    apply_set_op(m, k, r);
    expected_results.push_back(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_enable && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    set_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      beats_out <= beats_out + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result index=%0d status=%0d count=%0d",
                 $time, index, status, count);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (index !== exp_r.index) begin
          $display("%0t: index expected %0d actual %0d", $time, exp_r.index, index);
          errors++;
        end
        if (status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
          errors++;
        end
        if (count !== exp_r.count) begin
          $display("%0t: count expected %0d actual %0d", $time, exp_r.count, count);
          errors++;
        end
      end
    end
  end

  function automatic logic [dhis_pkg::KEY_W-1:0] rand_key();
    return $urandom();
  endfunction

  // Extremes of the key, every mode, misses and the spare mode code
  task automatic test_directed();
    send_op(dhis_pkg::MODE_LOOKUP, 32'h8000_0000);
    send_op(dhis_pkg::MODE_ERASE, 32'h0000_0000);
    send_op(dhis_pkg::MODE_INSERT, 32'h8000_0000);
    send_op(dhis_pkg::MODE_INSERT, 32'h7FFF_FFFF);
    send_op(dhis_pkg::MODE_INSERT, 32'h0000_0000);
    send_op(dhis_pkg::MODE_INSERT, 32'hFFFF_FFFF);
    send_op(dhis_pkg::MODE_INSERT, 32'h7FFF_FFFF);
    send_op(dhis_pkg::MODE_LOOKUP, 32'hFFFF_FFFF);
    send_op(2'd3, 32'h0000_0000);
    send_op(2'd3, 32'h1234_5678);
    send_op(dhis_pkg::MODE_INSERT, 32'h0000_0200);
    send_op(dhis_pkg::MODE_INSERT, 32'h0000_0400);
    send_op(dhis_pkg::MODE_ERASE, 32'h8000_0000);
    send_op(dhis_pkg::MODE_LOOKUP, 32'h0000_0400);
    send_op(dhis_pkg::MODE_ERASE, 32'h5555_5555);
    send_op(dhis_pkg::MODE_ERASE, 32'h0000_0400);
    send_op(dhis_pkg::MODE_LOOKUP, 32'h8000_0000);
    send_op(dhis_pkg::MODE_LOOKUP, 32'hAAAA_AAAA);
  endtask

  // Fill to capacity with colliding keys, hit full, then drain part of it
  task automatic test_fill_to_full();
    int unsigned guard;
    guard = 0;
    while (shadow_count < CAP && guard < 600) begin
      send_op(dhis_pkg::MODE_INSERT,
              ($urandom_range(0, 1) ? rand_key() : ($urandom_range(0, 63) << 9)));
      guard++;
    end
    send_op(dhis_pkg::MODE_INSERT, 32'h3C3C_3C3C);
    send_op(dhis_pkg::MODE_INSERT, 32'h8000_0001);
    send_op(dhis_pkg::MODE_INSERT, shadow_keys[shadow_count - 1]);
    send_op(dhis_pkg::MODE_LOOKUP, shadow_keys[0]);
    // hold off until the block is drained
    wait_drained();
    for (int i = 0; i < 40; i++)
      send_op(dhis_pkg::MODE_ERASE, shadow_keys[$urandom_range(0, shadow_count - 1)]);
  endtask

  // Half the keys drawn from stored ones when any are held, the rest fresh; some random mode codes
  task automatic test_random_mix(input int unsigned n_ops);
    logic [dhis_pkg::KEY_W-1:0] k;
    int unsigned sel;
    for (int i = 0; i < n_ops; i++) begin
      sel = $urandom_range(0, 9);
      if (shadow_count > 0 && sel < 5) k = shadow_keys[$urandom_range(0, shadow_count - 1)];
      else if (sel < 7) k = $urandom_range(0, 3) << $urandom_range(9, 31);
      else k = rand_key();
      if (sel == 9) send_op((dhis_pkg::MODE_W)'($urandom_range(0, 3)), k);
      else if (shadow_count > 150)
        send_op($urandom_range(0, 2) == 0 ? dhis_pkg::MODE_INSERT : dhis_pkg::MODE_ERASE, k);
      else send_op($urandom_range(0, 9) < 6 ? dhis_pkg::MODE_INSERT :
                   ($urandom_range(0, 1) ? dhis_pkg::MODE_ERASE : dhis_pkg::MODE_LOOKUP), k);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = dhis_pkg::MODE_INSERT;
    key = '0;
    errors = 0;
    beats_out = 0;
    cycles = 0;
    n_erased = 0;
    n_full = 0;
    stall_enable = 1'b1;
    shadow_count = 0;
    foreach (shadow_used[i]) shadow_used[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill_to_full();
    test_random_mix(650);
    stall_enable = 1'b0;
    test_random_mix(200);

    wait_drained();
    repeat (2000) @(posedge clk);
    $display("ran %0d result beats: %0d erases, %0d full rejects, final count %0d",
             beats_out, n_erased, n_full, shadow_count);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("double_hash_int_set: match");
    end else begin
      $display("%0d errors, %0d results missing", errors, expected_results.size());
      $display("double_hash_int_set: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dhis_pkg.sv
rtl/core/double_hash_int_set.sv
tb/double_hash_int_set_tb.sv
